// ----- src/tms_pkg.sv -----
`timescale 1ns / 1ps
package tms_pkg;
  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ENT_W       = $clog2(STACK_DEPTH);
  localparam int ADDR_W      = ENT_W + 4;
  // four rounded terms of up to 2^(62-FRAC_BITS) each, plus sign
  localparam int ACC_W       = 66 - FRAC_BITS;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_VIEW  = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
endpackage

// ----- src/tms_mac.sv -----
`timescale 1ns / 1ps
// One rounded Q-format product term, registered, plus an accumulator.
module tms_mac
  import tms_pkg::*;
(
  input  logic                     clk,
  input  logic                     clr,
  input  logic                     en,
  input  logic signed [31:0]       a,
  input  logic signed [31:0]       b,
  output logic signed [ACC_W-1:0]  acc
);
  logic signed [63:0]      prod_r;
  logic                    en_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [63:0]      rnd;

  always_comb begin
    rnd = (prod_r + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    en_r   <= en;
    if (clr) begin
      acc_r <= '0;
    end else if (en_r) begin
      acc_r <= acc_r + rnd[ACC_W-1:0];
    end
  end

  assign acc = acc_r;
endmodule

// ----- src/transform_matrix_stack.sv -----
`timescale 1ns / 1ps
// A pop, push or set-view result is registered on accept.
// Query: per product a setup, a 16-word load, a chained multiply per further
// entry (16 elements on the one shared MAC, then a copy), then 4 rows out.
// One item is taken at a time; a push of row 3 writes 16 store words and a set
// view writes 4, both through the single store write port.
// Sync active-low reset clears count, state, out_tvalid; store is not cleared.
module transform_matrix_stack
  import tms_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[1:0], row_index[3:2], value_0..value_3 [131:4], zero pad to 136
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_row[1:0], out_0..out_3 [129:2], status [131:130], zero pad to 136
  output logic [135:0] out_tdata,
  // which_matrix
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_CMT  = 8'b00000010,
    S_VIEW = 8'b00000100,
    S_PREP = 8'b00001000,
    S_LOAD = 8'b00010000,
    S_MUL  = 8'b00100000,
    S_COPY = 8'b01000000,
    S_EMIT = 8'b10000000
  } state_t;

  state_t state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] e_r;
  logic [ENT_W-1:0] slot_r;
  logic signed [31:0] mem [STACK_DEPTH*16];
  logic signed [31:0] pend [12];
  logic signed [31:0] mat_r [16];
  logic signed [31:0] tmp_r [16];
  logic signed [31:0] v_r [4];
  logic signed [31:0] rd_r;
  logic [1:0] row_r;
  logic [1:0] m_r;
  logic [1:0] orow_r;
  logic [4:0] idx_r;
  logic [2:0] ph_r;
  logic [3:0] el_r;
  logic [1:0] cmd;
  logic [1:0] row;
  logic signed [31:0] v [4];
  logic in_fire;
  logic mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic signed [31:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [1:0] k_feed;
  logic signed [31:0] mac_a;
  logic mac_clr, mac_en;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0] sat;
  logic resp_load, row_load;
  logic [1:0] resp_status;

  assign cmd = in_tdata[1:0];
  assign row = in_tdata[3:2];
  always_comb begin
    for (int c = 0; c < 4; c++) v[c] = in_tdata[4+32*c +: 32];
  end

  // One item in flight: input waits for idle and an empty result register.
  assign in_tready = (state_r == S_IDLE) && !out_tvalid;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    resp_status = ST_OK;
    if (cmd == CMD_PUSH && row == 2'd3 && cnt_r >= CNT_W'(STACK_DEPTH)) begin
      resp_status = ST_FULL;
    end else if (cmd == CMD_POP && cnt_r == '0) begin
      resp_status = ST_EMPTY;
    end
  end

  assign resp_load = in_fire && (cmd != CMD_QUERY);
  assign row_load  = (state_r == S_EMIT) && (!out_tvalid || out_tready);

  // Saturate the four-term sum of rounded products to 32 bits.
  always_comb begin
    if (acc > ACC_W'(32'sh7fffffff)) sat = 32'sh7fffffff;
    else if (acc < ACC_W'(32'sh80000000)) sat = 32'sh80000000;
    else sat = acc[31:0];
  end

  // S_MUL phases per element: 0..3 issue B[k][j] reads, 1..4 feed the MAC
  // with A[i][k] and the read data, 5 last term accumulates, 6 write back.
  assign k_feed  = 2'(ph_r - 3'd1);
  assign mac_a   = mat_r[{el_r[3:2], k_feed}];
  assign mac_en  = (state_r == S_MUL) && (ph_r >= 3'd1) && (ph_r <= 3'd4);
  assign mac_clr = (state_r == S_LOAD) || ((state_r == S_MUL) && (ph_r == 3'd6));

  tms_mac u_mac (.clk(clk), .clr(mac_clr), .en(mac_en), .a(mac_a), .b(rd_r),
    .acc(acc));

  // Store: one write and one registered read per cycle.
  assign mem_we = (state_r == S_CMT) || (state_r == S_VIEW);

  always_comb begin
    if (state_r == S_VIEW) begin
      wr_addr = {ENT_W'(1), row_r, idx_r[1:0]};
      wr_data = v_r[idx_r[1:0]];
    end else begin
      wr_addr = {slot_r, idx_r[3:0]};
      wr_data = (idx_r[3:2] == 2'd3) ? v_r[idx_r[1:0]] : pend[idx_r[3:0]];
    end
  end

  always_comb begin
    if (state_r == S_LOAD) rd_addr = {ENT_W'(m_r), idx_r[3:0]};
    else rd_addr = {e_r[ENT_W-1:0], ph_r[1:0], el_r[1:0]};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  // Rows 0..2 of a push wait here until row 3 commits the matrix.
  always_ff @(posedge clk) begin
    if (in_fire && cmd == CMD_PUSH && row != 2'd3) begin
      for (int c = 0; c < 4; c++) pend[{row, 2'(c)}] <= v[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            row_r  <= row;
            slot_r <= cnt_r[ENT_W-1:0];
            for (int c = 0; c < 4; c++) v_r[c] <= v[c];
            idx_r <= '0;
            m_r   <= '0;
            unique case (cmd)
              CMD_PUSH: begin
                if (row == 2'd3 && cnt_r < CNT_W'(STACK_DEPTH)) begin
                  cnt_r   <= cnt_r + CNT_W'(1);
                  state_r <= S_CMT;
                end
              end
              CMD_POP: begin
                if (cnt_r != '0) cnt_r <= cnt_r - CNT_W'(1);
              end
              CMD_VIEW:  state_r <= S_VIEW;
              CMD_QUERY: state_r <= S_PREP;
            endcase
          end
        end
        S_CMT: begin
          // pending rows 0..2 then the row carried by the item, one word a cycle
          idx_r <= idx_r + 5'd1;
          if (idx_r[3:0] == 4'hf) state_r <= S_IDLE;
        end
        S_VIEW: begin
          idx_r <= idx_r + 5'd1;
          if (idx_r[1:0] == 2'd3) state_r <= S_IDLE;
        end
        S_PREP: begin
          // product m chains entries m..count-1; none gives the identity
          idx_r  <= '0;
          orow_r <= '0;
          if (cnt_r > CNT_W'(m_r)) begin
            state_r <= S_LOAD;
          end else begin
            for (int x = 0; x < 16; x++) mat_r[x] <= (x % 5 == 0) ? ONE_FX : 32'sd0;
            state_r <= S_EMIT;
          end
        end
        S_LOAD: begin
          // read data lags the address through the registered store read
          idx_r <= idx_r + 5'd1;
          if (idx_r != 5'd0) mat_r[4'(idx_r - 5'd1)] <= rd_r;
          if (idx_r == 5'd16) begin
            e_r  <= CNT_W'(m_r) + CNT_W'(1);
            el_r <= '0;
            ph_r <= '0;
            state_r <= (CNT_W'(m_r) + CNT_W'(1) < cnt_r) ? S_MUL : S_EMIT;
          end
        end
        S_MUL: begin
          ph_r <= (ph_r == 3'd6) ? 3'd0 : ph_r + 3'd1;
          if (ph_r == 3'd6) begin
            tmp_r[el_r] <= sat;
            el_r <= el_r + 4'd1;
            if (el_r == 4'hf) state_r <= S_COPY;
          end
        end
        S_COPY: begin
          for (int x = 0; x < 16; x++) mat_r[x] <= tmp_r[x];
          e_r <= e_r + CNT_W'(1);
          state_r <= (e_r + CNT_W'(1) < cnt_r) ? S_MUL : S_EMIT;
        end
        S_EMIT: begin
          if (row_load) begin
            orow_r <= orow_r + 2'd1;
            if (orow_r == 2'd3) begin
              if (m_r == 2'd2) begin
                state_r <= S_IDLE;
              end else begin
                m_r <= m_r + 2'd1;
                state_r <= S_PREP;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result register: single-item results on accept, product rows in S_EMIT.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (resp_load || row_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_tuser <= 2'd0;
      out_tlast <= 1'b1;
      out_tdata <= {4'b0, resp_status, 128'b0, 2'b0};
    end else if (row_load) begin
      out_tuser <= m_r;
      out_tlast <= (m_r == 2'd2) && (orow_r == 2'd3);
      out_tdata <= {4'b0, ST_OK, mat_r[{orow_r, 2'd3}], mat_r[{orow_r, 2'd2}],
                    mat_r[{orow_r, 2'd1}], mat_r[{orow_r, 2'd0}], orow_r};
    end
  end

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH)) else $error("stack count overflow");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tready |=> !out_tvalid)
    else $error("result after last");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while waiting");
  a_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
endmodule
